[hw/rtl/tsc_pkg.sv]
// tsc_pkg: shared types, constants and reciprocal table for the taylor sine/cosine core
// no dependencies; used by tsc_half, tsc_term and taylor_sine_cosine_core

package tsc_pkg;

  // number of series terms evaluated per request
  localparam int MAX_TERMS = 6;
  // width of the term counter (holds 0 to MAX_TERMS)
  localparam int N_W = $clog2(MAX_TERMS + 1);
  // width of the power index (largest power is 2*MAX_TERMS)
  localparam int P_W = $clog2(2 * MAX_TERMS + 1);

  localparam logic signed [32:0] PI_Q28     = 33'sd843314856;
  localparam logic signed [32:0] TWO_PI_Q28 = 33'sd1686629712;
  localparam logic [34:0]        ONE_Q30    = 35'd1073741824;

  localparam logic [30:0] THRESH_RESET = 31'd1074;

  // request and result payloads
  typedef struct packed {
    logic              kind;
    logic signed [31:0] angle;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         terms_used;
  } result_t;

  // state carried down the pipeline with each request
  typedef struct packed {
    logic               skip;    // first sine term: no series step
    logic               tneg;    // sign of the next term
    logic               done;    // summation has stopped
    logic [N_W-1:0]     n;       // terms added so far
    logic [P_W-1:0]     p;       // power of the current term
    logic [29:0]        a;       // |x| in Q2.28
    logic [34:0]        t;       // term magnitude, 2^-30 units
    logic [34:0]        t_orig;  // term magnitude before the series step
    logic signed [37:0] acc;     // running sum, 2^-30 units
  } stage_t;

  // ceil(2^30 / d): exact quotient for dividends below 2^22, divisors up to 16
  localparam int RECIP_N = 17;
  localparam int RECIP_IW = $clog2(RECIP_N);
  localparam logic [30:0] RECIP [RECIP_N] = '{
    31'd0,
    31'((1073741824 + 0) / 1),
    31'((1073741824 + 1) / 2),
    31'((1073741824 + 2) / 3),
    31'((1073741824 + 3) / 4),
    31'((1073741824 + 4) / 5),
    31'((1073741824 + 5) / 6),
    31'((1073741824 + 6) / 7),
    31'((1073741824 + 7) / 8),
    31'((1073741824 + 8) / 9),
    31'((1073741824 + 9) / 10),
    31'((1073741824 + 10) / 11),
    31'((1073741824 + 11) / 12),
    31'((1073741824 + 12) / 13),
    31'((1073741824 + 13) / 14),
    31'((1073741824 + 14) / 15),
    31'((1073741824 + 15) / 16)
  };

  function automatic logic [30:0] recip(input logic [P_W-1:0] d);
    logic [30:0] r;
    r = '0;
    if (32'(d) < RECIP_N) begin
      r = RECIP[RECIP_IW'(d)];
    end
    return r;
  endfunction

endpackage

[hw/rtl/tsc_half.sv]
// tsc_half: one half of a series step, t = floor(t * a / 2^28) / d, over four stages
// depends on tsc_pkg (stage_t, recip)

module tsc_half (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  tsc_pkg::stage_t           in_data,
  input  logic [tsc_pkg::P_W-1:0]   in_div,
  output logic                      out_valid,
  output tsc_pkg::stage_t           out_data
);

  logic                    v1, v2, v3, v4;
  tsc_pkg::stage_t         s1, s2, s3, s4;
  tsc_pkg::stage_t         s4_next;
  logic [tsc_pkg::P_W-1:0] d1, d2, d3;
  logic [35:0]             y1;
  logic [17:0]             yh2, yl2, qh2;
  logic [17:0]             qh3;
  logic [21:0]             z3;

  logic [64:0] prod1;
  logic [48:0] prod2;
  logic [22:0] qd;
  logic [17:0] rh;
  logic [52:0] prod4;
  logic [17:0] ql;
  logic [35:0] q_full;

  // multiply by the angle magnitude
  assign prod1 = {30'b0, in_data.t} * {35'b0, in_data.a};
  // upper digit quotient by reciprocal
  assign prod2 = {31'b0, y1[35:18]} * {18'b0, tsc_pkg::recip(d1)};
  // upper digit remainder
  assign qd    = {5'b0, qh2} * 23'(d2);
  assign rh    = yh2 - qd[17:0];
  // lower digit quotient
  assign prod4 = {31'b0, z3} * {22'b0, tsc_pkg::recip(d3)};
  assign ql    = prod4[47:30];
  assign q_full = {qh3, ql};

  // last stage carries the quotient as the new term
  always_comb begin
    s4_next   = s3;
    s4_next.t = q_full[34:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= in_data;
      d1  <= in_div;
      y1  <= prod1[63:28];

      s2  <= s1;
      d2  <= d1;
      yh2 <= y1[35:18];
      yl2 <= y1[17:0];
      qh2 <= prod2[47:30];

      s3  <= s2;
      d3  <= d2;
      qh3 <= qh2;
      z3  <= {rh[3:0], yl2};

      s4  <= s4_next;
    end
  end

  assign out_valid = v4;
  assign out_data  = s4;

endmodule

[hw/rtl/tsc_term.sv]
// tsc_term: one series term, two half steps then the threshold test and accumulate
// depends on tsc_pkg and tsc_half

module tsc_term (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [30:0]     thr,
  input  logic            in_valid,
  input  tsc_pkg::stage_t in_data,
  output logic            out_valid,
  output tsc_pkg::stage_t out_data
);

  tsc_pkg::stage_t ent, mid, fin;
  logic            mid_valid, fin_valid;
  logic            acc_valid;
  tsc_pkg::stage_t acc_data;
  tsc_pkg::stage_t acc_next;
  logic [34:0]     term;
  logic signed [37:0] term_s;

  // advance the power unless this is the first sine term
  always_comb begin
    ent = in_data;
    ent.t_orig = in_data.t;
    if (!in_data.skip) begin
      ent.p = in_data.p + tsc_pkg::P_W'(2);
    end
  end

  tsc_half u_half_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (ent),
    .in_div    (ent.p - tsc_pkg::P_W'(1)),
    .out_valid (mid_valid),
    .out_data  (mid)
  );

  tsc_half u_half_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mid_valid),
    .in_data   (mid),
    .in_div    (mid.p),
    .out_valid (fin_valid),
    .out_data  (fin)
  );

  assign term   = fin.skip ? fin.t_orig : fin.t;
  assign term_s = $signed({3'b0, term});

  // threshold test and signed accumulate
  always_comb begin
    acc_next      = fin;
    acc_next.skip = 1'b0;
    acc_next.t    = term;
    if (!fin.done) begin
      if (term < {4'b0, thr}) begin
        acc_next.done = 1'b1;
      end else begin
        acc_next.acc  = fin.tneg ? fin.acc - term_s : fin.acc + term_s;
        acc_next.n    = fin.n + tsc_pkg::N_W'(1);
        acc_next.tneg = !fin.tneg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (en) begin
      acc_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_data <= acc_next;
    end
  end

  assign out_valid = acc_valid;
  assign out_data  = acc_data;

endmodule

[hw/rtl/taylor_sine_cosine_core.sv]
// Taylor series sine/cosine core. Each request enters a fixed pipeline: one stage
// of range reduction, nine stages per series term (two multiply-and-divide halves of
// four stages each, then the threshold test and accumulate), and one saturation
// stage. A new request is taken every cycle unless a held result stalls it; a stalled
// result holds the whole pipeline, and request_stall follows it in the same cycle.
// depends on tsc_pkg, tsc_term and tsc_half

module taylor_sine_cosine_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  tsc_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output tsc_pkg::result_t  result,
  input  logic              threshold_write,
  input  logic [30:0]       threshold_data
);

  logic [30:0] thr;
  logic        en;

  logic signed [32:0] x_in, x_red;
  logic [32:0]        x_abs;
  tsc_pkg::stage_t    init;

  logic            chain_valid [tsc_pkg::MAX_TERMS+1];
  tsc_pkg::stage_t chain_data  [tsc_pkg::MAX_TERMS+1];

  logic signed [37:0] last_acc;

  // whole pipeline moves unless the result is held
  assign en            = !(result_valid && result_stall);
  assign request_stall = !en;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= tsc_pkg::THRESH_RESET;
    end else if (threshold_write) begin
      thr <= threshold_data;
    end
  end

  // range reduction into [-pi, pi) and series start
  always_comb begin
    x_in = $signed({request.angle[31], request.angle});
    if (x_in >= tsc_pkg::PI_Q28) begin
      x_red = x_in - tsc_pkg::TWO_PI_Q28;
    end else if (x_in < -tsc_pkg::PI_Q28) begin
      x_red = x_in + tsc_pkg::TWO_PI_Q28;
    end else begin
      x_red = x_in;
    end
    x_abs = x_red[32] ? 33'(-x_red) : 33'(x_red);
    init.a      = x_abs[29:0];
    init.done   = 1'b0;
    init.n      = '0;
    init.t_orig = '0;
    if (request.kind) begin
      init.skip = 1'b0;
      init.tneg = 1'b1;
      init.p    = '0;
      init.t    = tsc_pkg::ONE_Q30;
      init.acc  = 38'sd1073741824;
    end else begin
      init.skip = 1'b1;
      init.tneg = x_red[32];
      init.p    = tsc_pkg::P_W'(1);
      init.t    = {3'b0, x_abs[29:0], 2'b0};
      init.acc  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (en) begin
      chain_valid[0] <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_data[0] <= init;
    end
  end

  // one unit per series term
  for (genvar k = 0; k < tsc_pkg::MAX_TERMS; k++) begin : g_term
    tsc_term u_term (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .thr       (thr),
      .in_valid  (chain_valid[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  assign last_acc = chain_data[tsc_pkg::MAX_TERMS].acc;

  // saturate to Q2.30 and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= chain_valid[tsc_pkg::MAX_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last_acc > 38'sd2147483647) begin
        result.value <= 32'sh7FFFFFFF;
      end else if (last_acc < -38'sd2147483648) begin
        result.value <= 32'sh80000000;
      end else begin
        result.value <= last_acc[31:0];
      end
      result.terms_used <= 4'(chain_data[tsc_pkg::MAX_TERMS].n);
    end
  end

  // checks
  a_terms_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.terms_used <= 4'(tsc_pkg::MAX_TERMS))
    else $error("terms_used beyond the term count");

  a_hold_back: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> request_stall)
    else $error("request taken while result held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_held_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(chain_valid[0]))
    else $error("pipeline moved while result held");

endmodule
